// ----- src/cgk_pkg.sv -----
// package: widths, types and codes for the carousel greedy knapsack block
package cgk_pkg;
   localparam int MAX_ITEMS = 1024;
   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = IDX_W + 1;
   localparam int VAL_W = 32;
   localparam int WGT_W = 32;
   localparam int CAP_W = 48;
   localparam int PROF_W = 42;
   localparam int RF_W = 4;
   localparam int FR_W = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUNDS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRACTION = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [VAL_W-1:0] item_value;
      logic [WGT_W-1:0] item_weight;
      logic             last_item;
   } req_type;

   typedef struct packed {
      logic [PROF_W-1:0] total_profit;
      logic [CAP_W-1:0]  total_weight;
      logic [CNT_W-1:0]  items_chosen;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CAP_W-1:0]     data;
   } csr_type;

   // solver configuration handed from the register file
   typedef struct packed {
      logic [CAP_W-1:0] capacity;
      logic [RF_W-1:0]  rounds_factor;
      logic [FR_W-1:0]  remove_fraction;
   } cfg_type;
endpackage

// ----- src/cgk_if.sv -----
// valid/ready channel interfaces
interface cgk_req_if import cgk_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cgk_rsp_if import cgk_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cgk_csr_if import cgk_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/cgk_regs.sv -----
// configuration registers
module cgk_regs import cgk_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cgk_csr_if.sink   csr,
   output cfg_type   cfg
);
   cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.data.index)
            CSR_CAPACITY: cfg_in.capacity = csr.data.data;
            CSR_ROUNDS:   cfg_in.rounds_factor = csr.data.data[RF_W-1:0];
            CSR_FRACTION: cfg_in.remove_fraction = csr.data.data[FR_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{capacity: '0, rounds_factor: RF_W'(1), remove_fraction: FR_W'(205)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// ----- src/cgk_mul.sv -----
// shared 32x32 multiplier with registered product
module cgk_mul import cgk_pkg::*; (
   input  logic                   clock,
   input  logic [VAL_W-1:0]       op_a,
   input  logic [WGT_W-1:0]       op_b,
   output logic [VAL_W+WGT_W-1:0] prod
);
   logic [VAL_W+WGT_W-1:0] prod_ff;

   // one product per cycle
   always_ff @(posedge clock) begin
      prod_ff <= {{WGT_W{1'b0}}, op_a} * {{VAL_W{1'b0}}, op_b};
   end

   assign prod = prod_ff;
endmodule

// ----- src/cgk_core.sv -----
// sequencer: load, sort, greedy fill, drop, carousel, final fill, report
module cgk_core import cgk_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   cgk_req_if.sink   req,
   cgk_rsp_if.source rsp
);
   typedef enum logic [29:0] {
      ST_LOAD  = 30'h0000_0001,
      ST_SI    = 30'h0000_0002,  // next item to insert, read its data
      ST_SV    = 30'h0000_0004,  // latch item data
      ST_SJ    = 30'h0000_0008,  // read ratio_order[j-1]
      ST_SB    = 30'h0000_0010,  // read data of that entry
      ST_SBD   = 30'h0000_0020,  // latch entry data
      ST_SM1   = 30'h0000_0040,  // product v_i*w_b
      ST_SM2   = 30'h0000_0080,  // product v_b*w_i
      ST_SM3   = 30'h0000_0100,  // compare and shift
      ST_SPUT  = 30'h0000_0200,  // place item i
      ST_WRD   = 30'h0000_0400,  // walk: read ratio_order[i]
      ST_WB    = 30'h0000_0800,  // walk: read free bit and weight
      ST_WCHK  = 30'h0000_1000,  // walk: test free and fit
      ST_DCALC = 30'h0000_2000,
      ST_DRD   = 30'h0000_4000,
      ST_DB    = 30'h0000_8000,
      ST_DW    = 30'h0001_0000,
      ST_ROUND = 30'h0002_0000,
      ST_RB    = 30'h0004_0000,
      ST_RW    = 30'h0008_0000,
      ST_RFREE = 30'h0010_0000,
      ST_MCLR  = 30'h0020_0000,  // clear in-bag marks
      ST_MSET  = 30'h0040_0000,  // read bag entry
      ST_MSW   = 30'h0080_0000,  // mark it in bag
      ST_MFREE = 30'h0100_0000,  // read in-bag mark of item i
      ST_MFW   = 30'h0200_0000,  // free it when outside the bag
      ST_SUM   = 30'h0400_0000,
      ST_SUB   = 30'h0800_0000,
      ST_SUV   = 30'h1000_0000,
      ST_OUT   = 30'h2000_0000
   } state_type;

   typedef logic [RF_W+CNT_W-1:0] rounds_type;

   // walk kinds
   localparam logic [1:0] WK_GREEDY1 = 2'd0;
   localparam logic [1:0] WK_FIRST = 2'd1;
   localparam logic [1:0] WK_GREEDY2 = 2'd2;

   logic [VAL_W-1:0] value_mem [MAX_ITEMS];
   logic [WGT_W-1:0] weight_mem [MAX_ITEMS];
   idx_type          order_mem [MAX_ITEMS];
   idx_type          bag_mem [MAX_ITEMS];
   logic             free_mem [MAX_ITEMS];
   logic             inbag_mem [MAX_ITEMS];

   state_type         state_ff;
   cnt_type           n_ff, i_ff, j_ff, k_ff, size_ff;
   idx_type           head_ff;
   logic              ovf_ff;
   logic [CAP_W-1:0]  fill_ff;
   logic [PROF_W-1:0] prof_ff;
   logic [1:0]        walk_ff;
   rounds_type        rounds_ff;
   idx_type           out_ff, b_ff;
   logic [VAL_W-1:0]  vi_ff, vb_ff;
   logic [WGT_W-1:0]  wi_ff, wb_ff;
   logic [63:0]       lprod_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   // registered memory reads
   idx_type          ord_q, bag_q;
   logic [VAL_W-1:0] val_q;
   logic [WGT_W-1:0] wgt_q;
   logic             free_q, inbag_q;

   logic [VAL_W-1:0] mul_a;
   logic [WGT_W-1:0] mul_b;
   logic [63:0]      prod;

   cgk_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod(prod));

   // product operands by phase
   always_comb begin
      if (state_ff == ST_SM1) begin
         mul_a = vi_ff; mul_b = wb_ff;
      end else begin
         mul_a = vb_ff; mul_b = wi_ff;
      end
   end

   // address selection
   idx_type ord_ra, bag_ra, it_ra;
   always_comb begin
      if (state_ff == ST_SJ) ord_ra = idx_type'(j_ff - cnt_type'(1));
      else ord_ra = i_ff[IDX_W-1:0];
      if (state_ff == ST_DRD) bag_ra = head_ff + idx_type'(size_ff - cnt_type'(1));
      else if (state_ff == ST_ROUND) bag_ra = head_ff;
      else bag_ra = head_ff + idx_type'(k_ff);
      if (state_ff == ST_SB || state_ff == ST_WB) it_ra = ord_q;
      else if (state_ff == ST_DB || state_ff == ST_RB || state_ff == ST_SUB) it_ra = bag_q;
      else it_ra = i_ff[IDX_W-1:0];
   end

   logic [CAP_W:0] fit_sum;
   assign fit_sum = {1'b0, fill_ff} + (CAP_W+1)'(wgt_q);

   // drop count and round budget from the first fill
   logic [CNT_W+FR_W-1:0] drop_prod;
   logic [FR_W-1:0]       frac;
   cnt_type               drop_cnt;
   rounds_type            rounds_prod;
   assign frac = (cfg.remove_fraction > FR_W'(1024)) ? FR_W'(1024) : cfg.remove_fraction;
   assign drop_prod = (CNT_W+FR_W)'(size_ff) * (CNT_W+FR_W)'(frac);
   assign drop_cnt = cnt_type'(drop_prod >> 10);
   assign rounds_prod = rounds_type'(cfg.rounds_factor) * rounds_type'(size_ff);

   logic rsp_load;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp.ready);

   assign req.ready = (state_ff == ST_LOAD);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   always_ff @(posedge clock) begin
      ord_q <= order_mem[ord_ra];
      bag_q <= bag_mem[bag_ra];
      val_q <= value_mem[it_ra];
      wgt_q <= weight_mem[it_ra];
      free_q <= free_mem[it_ra];
      inbag_q <= inbag_mem[it_ra];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_ff <= '{total_profit: prof_ff, total_weight: fill_ff,
                     items_chosen: size_ff, overflow: ovf_ff};
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         n_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (req.valid && req.ready) begin
                  if (n_ff < cnt_type'(MAX_ITEMS)) begin
                     value_mem[n_ff[IDX_W-1:0]] <= req.data.item_value;
                     weight_mem[n_ff[IDX_W-1:0]] <= req.data.item_weight;
                     n_ff <= n_ff + cnt_type'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req.data.last_item) begin
                     i_ff <= '0;
                     state_ff <= ST_SI;
                  end
               end
            end
            // insertion sort: item i against order[j-1]
            ST_SI: begin
               if (i_ff == n_ff) begin
                  walk_ff <= WK_GREEDY1;
                  size_ff <= '0; head_ff <= '0; fill_ff <= '0;
                  i_ff <= '0;
                  state_ff <= ST_WRD;
               end else begin
                  j_ff <= i_ff;
                  state_ff <= ST_SV;
               end
            end
            ST_SV: begin
               vi_ff <= val_q; wi_ff <= wgt_q;
               state_ff <= ST_SJ;
            end
            ST_SJ: begin
               if (j_ff == '0) state_ff <= ST_SPUT;
               else state_ff <= ST_SB;
            end
            ST_SB: begin
               b_ff <= ord_q;
               state_ff <= ST_SBD;
            end
            ST_SBD: begin
               vb_ff <= val_q; wb_ff <= wgt_q;
               state_ff <= ST_SM1;
            end
            ST_SM1: state_ff <= ST_SM2;
            ST_SM2: begin
               lprod_ff <= prod;
               state_ff <= ST_SM3;
            end
            ST_SM3: begin
               if (lprod_ff > prod) begin
                  order_mem[j_ff[IDX_W-1:0]] <= b_ff;
                  j_ff <= j_ff - cnt_type'(1);
                  state_ff <= ST_SJ;
               end else begin
                  state_ff <= ST_SPUT;
               end
            end
            ST_SPUT: begin
               order_mem[j_ff[IDX_W-1:0]] <= i_ff[IDX_W-1:0];
               free_mem[i_ff[IDX_W-1:0]] <= 1'b1;
               i_ff <= i_ff + cnt_type'(1);
               state_ff <= ST_SI;
            end
            // walk over ratio order
            ST_WRD: begin
               if (i_ff == n_ff ||
                   (walk_ff != WK_FIRST && fill_ff >= cfg.capacity)) begin
                  unique case (walk_ff)
                     WK_GREEDY1: state_ff <= ST_DCALC;
                     WK_FIRST:   state_ff <= ST_RFREE;
                     default: begin
                        k_ff <= '0; prof_ff <= '0;
                        state_ff <= ST_SUM;
                     end
                  endcase
               end else begin
                  state_ff <= ST_WB;
               end
            end
            ST_WB: begin
               b_ff <= ord_q;
               state_ff <= ST_WCHK;
            end
            ST_WCHK: begin
               if (free_q && fit_sum <= {1'b0, cfg.capacity}) begin
                  bag_mem[head_ff + idx_type'(size_ff)] <= b_ff;
                  size_ff <= size_ff + cnt_type'(1);
                  fill_ff <= fit_sum[CAP_W-1:0];
                  free_mem[b_ff] <= 1'b0;
                  if (walk_ff == WK_FIRST) begin
                     state_ff <= ST_RFREE;
                  end else begin
                     i_ff <= i_ff + cnt_type'(1);
                     state_ff <= ST_WRD;
                  end
               end else begin
                  i_ff <= i_ff + cnt_type'(1);
                  state_ff <= ST_WRD;
               end
            end
            // drop newest items, they stay taken
            ST_DCALC: begin
               rounds_ff <= rounds_prod;
               if (drop_cnt == '0 && cfg.rounds_factor == '0) begin
                  k_ff <= '0; prof_ff <= '0;
                  state_ff <= ST_SUM;
               end else begin
                  k_ff <= drop_cnt;
                  state_ff <= ST_DRD;
               end
            end
            ST_DRD: begin
               if (k_ff == '0) state_ff <= ST_ROUND;
               else state_ff <= ST_DB;
            end
            ST_DB: state_ff <= ST_DW;
            ST_DW: begin
               fill_ff <= fill_ff - CAP_W'(wgt_q);
               size_ff <= size_ff - cnt_type'(1);
               k_ff <= k_ff - cnt_type'(1);
               state_ff <= ST_DRD;
            end
            // carousel round: evict oldest, add first fit, then free evicted
            ST_ROUND: begin
               if (rounds_ff == '0 || size_ff == '0) begin
                  i_ff <= '0;
                  state_ff <= ST_MCLR;
               end else begin
                  state_ff <= ST_RB;
               end
            end
            ST_RB: begin
               out_ff <= bag_q;
               state_ff <= ST_RW;
            end
            ST_RW: begin
               fill_ff <= fill_ff - CAP_W'(wgt_q);
               head_ff <= head_ff + idx_type'(1);
               size_ff <= size_ff - cnt_type'(1);
               rounds_ff <= rounds_ff - rounds_type'(1);
               walk_ff <= WK_FIRST;
               i_ff <= '0;
               state_ff <= ST_WRD;
            end
            ST_RFREE: begin
               free_mem[out_ff] <= 1'b1;
               state_ff <= ST_ROUND;
            end
            // rebuild free bits: clear in-bag marks, set from bag, free the rest
            ST_MCLR: begin
               if (i_ff == n_ff) begin
                  k_ff <= '0;
                  state_ff <= ST_MSET;
               end else begin
                  inbag_mem[i_ff[IDX_W-1:0]] <= 1'b0;
                  i_ff <= i_ff + cnt_type'(1);
               end
            end
            ST_MSET: begin
               if (k_ff == size_ff) begin
                  i_ff <= '0;
                  state_ff <= ST_MFREE;
               end else begin
                  state_ff <= ST_MSW;
               end
            end
            ST_MSW: begin
               inbag_mem[bag_q] <= 1'b1;
               k_ff <= k_ff + cnt_type'(1);
               state_ff <= ST_MSET;
            end
            ST_MFREE: begin
               if (i_ff == n_ff) begin
                  walk_ff <= WK_GREEDY2;
                  i_ff <= '0;
                  state_ff <= ST_WRD;
               end else begin
                  state_ff <= ST_MFW;
               end
            end
            ST_MFW: begin
               if (!inbag_q) free_mem[i_ff[IDX_W-1:0]] <= 1'b1;
               i_ff <= i_ff + cnt_type'(1);
               state_ff <= ST_MFREE;
            end
            // sum profit of bag
            ST_SUM: begin
               if (k_ff == size_ff) state_ff <= ST_OUT;
               else state_ff <= ST_SUB;
            end
            ST_SUB: state_ff <= ST_SUV;
            ST_SUV: begin
               prof_ff <= prof_ff + PROF_W'(val_q);
               k_ff <= k_ff + cnt_type'(1);
               state_ff <= ST_SUM;
            end
            ST_OUT: begin
               if (rsp_load) begin
                  n_ff <= '0;
                  ovf_ff <= 1'b0;
                  state_ff <= ST_LOAD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end
endmodule

// ----- src/carousel_greedy_knapsack.sv -----
// top level of the carousel greedy knapsack solver
//  channel | dir | payload
//  req     | in  | item_value, item_weight, last_item
//  rsp     | out | total_profit, total_weight, items_chosen, overflow
//  csr     | in  | index (0 capacity, 1 rounds_factor, 2 remove_fraction), data
// items load one per cycle; after the last item the solve runs on one shared
// multiplier and single-address store reads through the sort, each greedy walk
// and each carousel round
// reset is synchronous and returns the registers to their reset values
// req is stalled from the last item beat until the result is handed to rsp;
// a solve that ends while the previous result waits holds until it is taken
module carousel_greedy_knapsack import cgk_pkg::*; (
   input logic       clock,
   input logic       reset,
   cgk_req_if.sink   req,
   cgk_rsp_if.source rsp,
   cgk_csr_if.sink   csr
);
   cfg_type cfg;

   cgk_regs u_regs (.clock(clock), .reset(reset), .csr(csr), .cfg(cfg));
   cgk_core u_core (.clock(clock), .reset(reset), .cfg(cfg), .req(req), .rsp(rsp));

`ifndef SYNTH
   // no input beat right after the last item of an instance
   a_solve_blocks_req: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.data.last_item |=> !req.ready)
      else $error("req ready right after last item");
   // result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("rsp dropped");
`endif
endmodule
